FILE: hw/rtl/scs_pkg.sv
// ----------------------------------------------------------------------------
// Sine/cosine series package
// Shared widths, constants and the lane record that passes between cells.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int TERMS_DEF = 10;
    localparam int FRAC_BITS = 28;
    localparam int ANGLE_W = 31;
    localparam int VALUE_W = 30;
    localparam int X2_W = 32;
    localparam int TERM_W = 32;
    localparam int SUM_W = 34;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 31'sd843314857;
    localparam logic signed [SUM_W-1:0] ONE_Q = 34'sd268435456;

    typedef enum logic {
        FUNC_SIN = 1'b0,
        FUNC_COS = 1'b1
    } t_func;

    typedef struct packed {
        logic valid;
        logic func;
        logic err;
        logic [X2_W-1:0] x2;
        logic signed [TERM_W-1:0] term;
        logic signed [SUM_W-1:0] sum;
    } t_lane;

endpackage

FILE: hw/rtl/scs_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one sine or cosine request per item.
// ----------------------------------------------------------------------------
interface scs_in_if;
    logic valid;
    logic ready;
    logic func;
    logic signed [30:0] angle;

    modport source(output valid, output func, output angle, input ready);
    modport sink(input valid, input func, input angle, output ready);
endinterface

FILE: hw/rtl/scs_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Carries one series result per item.
// ----------------------------------------------------------------------------
interface scs_out_if;
    logic valid;
    logic ready;
    logic signed [29:0] value;
    logic range_error;

    modport source(output valid, output value, output range_error, input ready);
    modport sink(input valid, input value, input range_error, output ready);
endinterface

FILE: hw/rtl/scs_front.sv
// ----------------------------------------------------------------------------
// Series front stage
// Checks the angle range, squares the angle and seeds the first term.
// ----------------------------------------------------------------------------
module scs_front
    import scs_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic                      i_func,
    input  logic signed [ANGLE_W-1:0] i_angle,
    output t_lane                     o_lane
);

    logic r_valid;
    logic r_func;
    logic r_err;
    logic [2*ANGLE_W-1:0] r_sq;
    logic signed [TERM_W-1:0] r_term;

    logic signed [2*ANGLE_W-1:0] n_ext;
    logic signed [2*ANGLE_W-1:0] n_sq;
    logic signed [TERM_W-1:0] n_term;
    logic n_err;

    always_comb begin
        n_ext = {{ANGLE_W{i_angle[ANGLE_W-1]}}, i_angle};
        n_sq = n_ext * n_ext;
        n_err = (i_angle > ANGLE_LIMIT) || (i_angle < -ANGLE_LIMIT);
        if (i_func == FUNC_COS) begin
            n_term = TERM_W'(ONE_Q);
        end else begin
            n_term = {{(TERM_W-ANGLE_W){i_angle[ANGLE_W-1]}}, i_angle};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_func <= i_func;
            r_err <= n_err;
            r_sq <= n_sq;
            r_term <= n_term;
        end
    end

    always_comb begin
        o_lane.valid = r_valid;
        o_lane.func = r_func;
        o_lane.err = r_err;
        o_lane.x2 = r_sq[FRAC_BITS+X2_W-1:FRAC_BITS];
        o_lane.term = r_term;
        o_lane.sum = {{(SUM_W-TERM_W){r_term[TERM_W-1]}}, r_term};
    end

endmodule

FILE: hw/rtl/scs_cell.sv
// ----------------------------------------------------------------------------
// Series term cell
// Forms the next term from the previous one and adds it to the running sum.
// ----------------------------------------------------------------------------
module scs_cell
    import scs_pkg::*;
#(
    parameter int IDX = 1
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_lane i_lane,
    output t_lane o_lane
);

    localparam int K_SIN = 2 * IDX;
    localparam int K_COS = 2 * IDX - 1;
    localparam int D_W = 11;
    localparam int N_W = 34;
    localparam int H_W = 17;
    localparam int M_W = 34;
    localparam int Q_W = 33;
    localparam logic [D_W-1:0] D_SIN = D_W'(K_SIN * (K_SIN + 1));
    localparam logic [D_W-1:0] D_COS = D_W'(K_COS * (K_COS + 1));
    localparam logic [M_W-1:0] M_SIN = M_W'((64'd1 << N_W) / (K_SIN * (K_SIN + 1)));
    localparam logic [M_W-1:0] M_COS = M_W'((64'd1 << N_W) / (K_COS * (K_COS + 1)));

    t_lane r_a, r_b, r_c, r_d, r_e;
    logic signed [64:0] r_prod;
    logic [H_W+M_W-1:0] r_ph, r_pl;
    logic [N_W-1:0] r_nb, r_nc, r_nd;
    logic r_negb, r_negc, r_negd;
    logic [Q_W-1:0] r_qc, r_qd;
    logic [N_W:0] r_qdp;

    logic signed [64:0] n_prod;
    logic signed [N_W:0] n_p;
    logic n_neg;
    logic [N_W-1:0] n_n;
    logic [M_W-1:0] n_m;
    logic [H_W+M_W+H_W:0] n_s;
    logic [D_W-1:0] n_dd;
    logic [Q_W+D_W-1:0] n_qdp;
    logic [D_W-1:0] n_de;
    logic [N_W:0] n_r;
    logic [Q_W-1:0] n_q;
    logic signed [TERM_W-1:0] n_term;

    always_comb begin
        n_prod = $signed({{33{i_lane.term[TERM_W-1]}}, i_lane.term})
               * $signed({33'b0, i_lane.x2});
        n_p = r_prod[FRAC_BITS+N_W:FRAC_BITS];
        n_neg = n_p[N_W];
        n_n = n_neg ? N_W'(-n_p) : N_W'(n_p);
        n_m = (r_a.func == FUNC_COS) ? M_COS : M_SIN;
        n_s = {r_ph, {H_W{1'b0}}} + (H_W+M_W+H_W+1)'(r_pl);
        n_dd = (r_c.func == FUNC_COS) ? D_COS : D_SIN;
        n_qdp = r_qc * (Q_W+D_W)'(n_dd);
        n_de = (r_d.func == FUNC_COS) ? D_COS : D_SIN;
        n_r = {1'b0, r_nd} - r_qdp;
        if (n_r >= (N_W+1)'({n_de, 1'b0})) begin
            n_q = r_qd + Q_W'(2);
        end else if (n_r >= (N_W+1)'(n_de)) begin
            n_q = r_qd + Q_W'(1);
        end else begin
            n_q = r_qd;
        end
        n_term = r_negd ? TERM_W'(n_q) : -TERM_W'(n_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_c.valid <= 1'b0;
            r_d.valid <= 1'b0;
            r_e.valid <= 1'b0;
        end else if (i_en) begin
            r_a.valid <= i_lane.valid;
            r_b.valid <= r_a.valid;
            r_c.valid <= r_b.valid;
            r_d.valid <= r_c.valid;
            r_e.valid <= r_d.valid;
        end
        if (i_en) begin
            {r_a.func, r_a.err, r_a.x2, r_a.term, r_a.sum} <=
                {i_lane.func, i_lane.err, i_lane.x2, i_lane.term, i_lane.sum};
            {r_b.func, r_b.err, r_b.x2, r_b.term, r_b.sum} <=
                {r_a.func, r_a.err, r_a.x2, r_a.term, r_a.sum};
            {r_c.func, r_c.err, r_c.x2, r_c.term, r_c.sum} <=
                {r_b.func, r_b.err, r_b.x2, r_b.term, r_b.sum};
            {r_d.func, r_d.err, r_d.x2, r_d.term, r_d.sum} <=
                {r_c.func, r_c.err, r_c.x2, r_c.term, r_c.sum};
            r_e.func <= r_d.func;
            r_e.err <= r_d.err;
            r_e.x2 <= r_d.x2;
            r_e.term <= n_term;
            r_e.sum <= r_d.sum + {{(SUM_W-TERM_W){n_term[TERM_W-1]}}, n_term};
            r_prod <= n_prod;
            r_ph <= n_n[N_W-1:H_W] * n_m;
            r_pl <= n_n[H_W-1:0] * n_m;
            r_nb <= n_n;
            r_negb <= n_neg;
            r_qc <= n_s[N_W+Q_W-1:N_W];
            r_nc <= r_nb;
            r_negc <= r_negb;
            r_qd <= r_qc;
            r_qdp <= n_qdp[N_W:0];
            r_nd <= r_nc;
            r_negd <= r_negc;
        end
    end

    assign o_lane = r_e;

`ifndef NO_ASSERTIONS
    a_quot_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d.valid |-> (r_qdp <= {1'b0, r_nd}))
        else $error("quotient estimate exceeds the true quotient");
    a_quot_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d.valid |-> (n_r < (N_W+1)'(3 * n_de)))
        else $error("quotient estimate needs more than two corrections");
    a_sum_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_d.valid) |=> (r_e.sum == $past(r_d.sum) + r_e.term))
        else $error("running sum does not take the new term");
`endif

endmodule

FILE: hw/rtl/scs_out.sv
// ----------------------------------------------------------------------------
// Series output stage
// Saturates the final sum, applies the range error and holds the result item.
// ----------------------------------------------------------------------------
module scs_out
    import scs_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_lane                     i_lane,
    input  logic                      i_ready,
    output logic                      o_en,
    output logic                      o_valid,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_range_error
);

    logic r_valid;
    logic signed [VALUE_W-1:0] r_value;
    logic r_err;
    logic signed [VALUE_W-1:0] n_value;

    assign o_en = !r_valid || i_ready;

    always_comb begin
        if (i_lane.err) begin
            n_value = '0;
        end else if (i_lane.sum > ONE_Q) begin
            n_value = VALUE_W'(ONE_Q);
        end else if (i_lane.sum < -ONE_Q) begin
            n_value = VALUE_W'(-ONE_Q);
        end else begin
            n_value = i_lane.sum[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_lane.valid;
        end
        if (o_en) begin
            r_value <= n_value;
            r_err <= i_lane.err;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_range_error = r_err;

endmodule

FILE: hw/rtl/sine_cosine_series.sv
// ----------------------------------------------------------------------------
// Sine/cosine series
// Maclaurin series sine and cosine in Q1.28 built as a chain of term cells.
//
//   channel   dir  fields
//   i_in      in   func, angle
//   o_out     out  value, range_error
//
// One item enters every cycle while the result is not stalled.
// Each term cell is five stages deep: multiply, reciprocal products,
// quotient estimate, back product and correction with accumulation.
// Reset clears only the valid bits of the stages.
// A stalled result freezes the whole chain; i_in.ready follows the output side.
// ----------------------------------------------------------------------------
module sine_cosine_series
    import scs_pkg::*;
#(
    parameter int TERMS = TERMS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scs_in_if.sink    i_in,
    scs_out_if.source o_out
);

    logic en;
    t_lane lane [TERMS];

    assign i_in.ready = en;

    scs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_func  (i_in.func),
        .i_angle (i_in.angle),
        .o_lane  (lane[0])
    );

    for (genvar g = 1; g < TERMS; g++) begin : g_cell
        scs_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_lane  (lane[g-1]),
            .o_lane  (lane[g])
        );
    end

    scs_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_lane        (lane[TERMS-1]),
        .i_ready       (o_out.ready),
        .o_en          (en),
        .o_valid       (o_out.valid),
        .o_value       (o_out.value),
        .o_range_error (o_out.range_error)
    );

endmodule
